// File: rtl/mpo_pkg.sv
// ----------------------------------------------------------------------------
// mpo_pkg: shared types and helpers for the Morton point ordering block
// Constants, sequencer states, the quantizer status bundle and bit interleave.
// ----------------------------------------------------------------------------
package mpo_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int AXIS_BITS_DEF  = 21;
	localparam int AXIS_MAX_BITS  = 21;
	localparam int CODE_W         = 63;
	localparam int NODE_W         = 10;
	localparam int COORD_W        = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDPT,
		ST_QST,
		ST_DIV,
		ST_CODE,
		ST_RDO,
		ST_RDC,
		ST_CMP,
		ST_INS,
		ST_R_ORD,
		ST_R_CODE,
		ST_R_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} quant_stat_t;

	function automatic logic [CODE_W-1:0] interleave(
		input logic [AXIS_MAX_BITS-1:0] qx,
		input logic [AXIS_MAX_BITS-1:0] qy,
		input logic [AXIS_MAX_BITS-1:0] qz
	);
		logic [CODE_W-1:0] c;
		c = '0;
		for (int b = 0; b < AXIS_MAX_BITS; b++) begin
			c[3*b]     = qx[b];
			c[3*b + 1] = qy[b];
			c[3*b + 2] = qz[b];
		end
		return c;
	endfunction

endpackage

// File: rtl/morton_point_ordering.sv
// ----------------------------------------------------------------------------
// morton_point_ordering: load 3D points, sort by Morton code, read out
// Points go to a coordinate RAM; a sort pass codes and insertion-sorts them
// into an order RAM; reads stream the ordered node indexes and codes.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | side band
// s_      | in  | coord_x, coord_y, coord_z               | tuser = op
// m_      | out | node_index, morton_code                 | tlast = last
//
// A load goes straight into the coordinate RAM; an ordered read steps through
// R_ORD, R_CODE and R_OUT (two dependent RAM reads) and waits in R_CODE while
// the previous result beat still waits on m_tready. The sort pass is paced by
// the serial divider and the one-port order/code RAMs; intake is held meanwhile.
// Reset clears control and the box; RAM contents are unknown until loaded.
// A pending result beat holds the next readout, and intake waits while that readout does.
// ----------------------------------------------------------------------------
module morton_point_ordering #(
	parameter int MAX_POINTS = mpo_pkg::MAX_POINTS_DEF,
	parameter int AXIS_BITS  = mpo_pkg::AXIS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // coord_x, coord_y, coord_z
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // node_index, morton_code, zero pad
	output logic        m_tlast
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	mpo_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, rp_q, i_q, j_q;
	logic          sorted_q;
	logic [2:0][31:0] lo_q, hi_q;
	logic [IW-1:0] prev_q;
	logic [mpo_pkg::CODE_W-1:0] c_q;

	logic          m_valid_q, m_last_q;
	logic [mpo_pkg::NODE_W-1:0] m_node_q, node_s;
	logic [mpo_pkg::CODE_W-1:0] m_code_q;

	logic          acc, acc_load, acc_read;
	logic          full;

	logic          crd_we, ord_we, cod_we;
	logic [IW-1:0] crd_addr, ord_addr, cod_addr;
	logic [95:0]   crd_rdata;
	logic [IW-1:0] ord_wdata, ord_rdata;
	logic [mpo_pkg::CODE_W-1:0] cod_rdata;

	logic                        q_start;
	logic [2:0][31:0]            q_v;
	logic [2:0][AXIS_BITS-1:0]   q_res;
	mpo_pkg::quant_stat_t        q_stat;
	logic [31:0]                 node_ext;
	logic                        shift_go;

	assign s_tready = (state_q == mpo_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign acc_load = acc && (s_tuser == mpo_pkg::OP_LOAD);
	assign acc_read = acc && (s_tuser == mpo_pkg::OP_READ);
	assign full     = (count_q >= CW'(MAX_POINTS));
	assign shift_go = (cod_rdata > c_q);
	assign node_ext = 32'(ord_rdata);
	assign node_s   = node_ext[mpo_pkg::NODE_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpo_pkg::ST_IDLE: begin
				if (acc_read && count_q != '0) begin
					state_d = sorted_q ? mpo_pkg::ST_R_ORD : mpo_pkg::ST_RDPT;
				end
			end
			mpo_pkg::ST_RDPT:   state_d = mpo_pkg::ST_QST;
			mpo_pkg::ST_QST:    state_d = mpo_pkg::ST_DIV;
			mpo_pkg::ST_DIV:    if (q_stat.done) state_d = mpo_pkg::ST_CODE;
			mpo_pkg::ST_CODE:   state_d = (i_q == '0) ? mpo_pkg::ST_INS : mpo_pkg::ST_RDO;
			mpo_pkg::ST_RDO:    state_d = mpo_pkg::ST_RDC;
			mpo_pkg::ST_RDC:    state_d = mpo_pkg::ST_CMP;
			mpo_pkg::ST_CMP: begin
				if (shift_go && j_q != CW'(1)) begin
					state_d = mpo_pkg::ST_RDO;
				end else begin
					state_d = mpo_pkg::ST_INS;
				end
			end
			mpo_pkg::ST_INS: begin
				state_d = (i_q + 1'b1 == count_q) ? mpo_pkg::ST_IDLE : mpo_pkg::ST_RDPT;
			end
			mpo_pkg::ST_R_ORD:  state_d = mpo_pkg::ST_R_CODE;
			// hold the code read until the output register is free
			mpo_pkg::ST_R_CODE: begin
				if (!m_valid_q || m_tready) begin
					state_d = mpo_pkg::ST_R_OUT;
				end
			end
			mpo_pkg::ST_R_OUT:  state_d = mpo_pkg::ST_IDLE;
			default:            state_d = mpo_pkg::ST_IDLE;
		endcase
	end

	// RAM and quantizer controls
	always_comb begin
		crd_we    = 1'b0;
		crd_addr  = i_q[IW-1:0];
		ord_we    = 1'b0;
		ord_addr  = j_q[IW-1:0];
		ord_wdata = i_q[IW-1:0];
		cod_we    = 1'b0;
		cod_addr  = ord_rdata;
		q_start   = 1'b0;
		case (state_q)
			mpo_pkg::ST_IDLE: begin
				crd_addr = count_q[IW-1:0];
				crd_we   = acc_load && !sorted_q && !full;
			end
			mpo_pkg::ST_QST:  q_start = 1'b1;
			mpo_pkg::ST_CODE: begin
				cod_we   = 1'b1;
				cod_addr = i_q[IW-1:0];
			end
			mpo_pkg::ST_RDO:  ord_addr = IW'(j_q - 1'b1);
			mpo_pkg::ST_CMP: begin
				ord_we    = shift_go;
				ord_wdata = prev_q;
			end
			mpo_pkg::ST_INS:  ord_we = 1'b1;
			mpo_pkg::ST_R_ORD:  ord_addr = rp_q[IW-1:0];
			mpo_pkg::ST_R_CODE: ord_addr = rp_q[IW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mpo_pkg::ST_IDLE;
			count_q   <= '0;
			rp_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			sorted_q  <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				mpo_pkg::ST_IDLE: begin
					if (crd_we) begin
						for (int a = 0; a < 3; a++) begin
							if (count_q == '0 || $signed(s_tdata[32*a +: 32]) < $signed(lo_q[a])) begin
								lo_q[a] <= s_tdata[32*a +: 32];
							end
							if (count_q == '0 || $signed(s_tdata[32*a +: 32]) > $signed(hi_q[a])) begin
								hi_q[a] <= s_tdata[32*a +: 32];
							end
						end
						count_q <= count_q + 1'b1;
					end
					if (acc_read && count_q != '0 && !sorted_q) begin
						i_q <= '0;
					end
				end
				mpo_pkg::ST_CODE: j_q <= i_q;
				mpo_pkg::ST_CMP:  if (shift_go) j_q <= j_q - 1'b1;
				mpo_pkg::ST_INS: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == count_q) begin
						sorted_q <= 1'b1;
						rp_q     <= '0;
					end
				end
				mpo_pkg::ST_R_OUT: begin
					m_valid_q <= 1'b1;
					if (rp_q + 1'b1 >= count_q) begin
						count_q  <= '0;
						rp_q     <= '0;
						sorted_q <= 1'b0;
						lo_q     <= '0;
						hi_q     <= '0;
					end else begin
						rp_q <= rp_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == mpo_pkg::ST_DIV && q_stat.done) begin
			c_q <= mpo_pkg::interleave(mpo_pkg::AXIS_MAX_BITS'(q_res[0]),
				mpo_pkg::AXIS_MAX_BITS'(q_res[1]), mpo_pkg::AXIS_MAX_BITS'(q_res[2]));
		end
		if (state_q == mpo_pkg::ST_RDC) begin
			prev_q <= ord_rdata;
		end
		if (state_q == mpo_pkg::ST_R_OUT) begin
			m_node_q <= node_s;
			m_code_q <= cod_rdata;
			m_last_q <= (rp_q + 1'b1 >= count_q);
		end
	end

	assign q_v[0] = crd_rdata[31:0];
	assign q_v[1] = crd_rdata[63:32];
	assign q_v[2] = crd_rdata[95:64];

	mpo_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_crd (
		.clk(clk), .we(crd_we), .addr(crd_addr), .wdata(s_tdata), .rdata(crd_rdata)
	);

	mpo_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_ord (
		.clk(clk), .we(ord_we), .addr(ord_addr), .wdata(ord_wdata), .rdata(ord_rdata)
	);

	mpo_ram #(.WIDTH(mpo_pkg::CODE_W), .DEPTH(MAX_POINTS)) u_cod (
		.clk(clk), .we(cod_we), .addr(cod_addr), .wdata(c_q), .rdata(cod_rdata)
	);

	mpo_quant #(.AXIS_BITS(AXIS_BITS)) u_quant (
		.clk(clk), .arst_n(arst_n), .start(q_start), .v(q_v), .lo(lo_q), .hi(hi_q),
		.q(q_res), .stat(q_stat)
	);

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {7'b0, m_code_q, m_node_q};

`ifndef NO_ASSERTIONS
	a_beat_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == mpo_pkg::ST_R_OUT))
		else $error("result beat without readout");
	a_no_ord_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpo_pkg::ST_IDLE) |-> !ord_we && !cod_we)
		else $error("order or code write while idle");
	a_quant_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.done |-> (state_q == mpo_pkg::ST_DIV))
		else $error("quantizer finished outside divide wait");
	a_sorted_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_q |-> (count_q != '0) && (rp_q < count_q))
		else $error("sorted set with bad pointer");
`endif

endmodule

// File: rtl/mpo_ram.sv
// ----------------------------------------------------------------------------
// mpo_ram: generic single-port synchronous RAM
// One access per cycle, read data registered.
// ----------------------------------------------------------------------------
module mpo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/mpo_quant.sv
// ----------------------------------------------------------------------------
// mpo_quant: three-axis quantizer
// round((v-lo)*M/span) half up, as (2*off*M+span)/(2*span) by restoring
// division, one quotient bit per cycle and axis.
// ----------------------------------------------------------------------------
module mpo_quant #(
	parameter int AXIS_BITS = mpo_pkg::AXIS_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [2:0][mpo_pkg::COORD_W-1:0]         v,
	input  logic [2:0][mpo_pkg::COORD_W-1:0]         lo,
	input  logic [2:0][mpo_pkg::COORD_W-1:0]         hi,
	output logic [2:0][AXIS_BITS-1:0]                q,
	output mpo_pkg::quant_stat_t                     stat
);

	localparam int NW = 34 + AXIS_BITS;
	localparam int RW = 35;
	localparam int CW = $clog2(AXIS_BITS + 1);
	localparam logic [AXIS_BITS-1:0] AXIS_MAX = '1;

	logic [2:0][31:0]      off_q, span_q;
	logic [2:0]            zero_q;
	logic [2:0][NW-1:0]    num_q;
	logic [2:0][RW-1:0]    rem_q;
	logic [2:0][32:0]      dvs_q;
	logic                  busy_q, mul_q, done_q;
	logic [CW-1:0]         cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				cnt_q <= CW'(AXIS_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [32:0] d_span, d_off;
		logic [RW-1:0]      trial;
		logic [NW-1:0]      prod;

		assign d_span = {hi[a][31], hi[a]} - {lo[a][31], lo[a]};
		assign d_off  = {v[a][31], v[a]} - {lo[a][31], lo[a]};
		assign prod   = NW'({off_q[a], 1'b0}) * NW'(AXIS_MAX) + NW'(span_q[a]);
		assign trial  = {rem_q[a][RW-2:0], num_q[a][AXIS_BITS-1]};

		always_ff @(posedge clk) begin
			if (start) begin
				span_q[a] <= d_span[31:0];
				zero_q[a] <= (d_span == '0);
				if (d_off[32]) begin
					off_q[a] <= '0;
				end else if (d_off > d_span) begin
					off_q[a] <= d_span[31:0];
				end else begin
					off_q[a] <= d_off[31:0];
				end
			end else if (mul_q) begin
				// low dividend bits stay at the bottom and shift up into the trial bit
				num_q[a] <= prod;
				rem_q[a] <= RW'(prod[NW-1:AXIS_BITS]);
				dvs_q[a] <= {span_q[a], 1'b0};
			end else if (busy_q) begin
				num_q[a] <= num_q[a] << 1;
				// zero span: every quotient bit is 0
				if (!zero_q[a] && trial >= RW'(dvs_q[a])) begin
					rem_q[a] <= trial - RW'(dvs_q[a]);
					q[a]     <= {q[a][AXIS_BITS-2 >= 0 ? AXIS_BITS-2 : 0:0], 1'b1} & AXIS_MAX;
				end else begin
					rem_q[a] <= trial;
					q[a]     <= {q[a][AXIS_BITS-2 >= 0 ? AXIS_BITS-2 : 0:0], 1'b0} & AXIS_MAX;
				end
			end else if (done_q && zero_q[a]) begin
				q[a] <= '0;
			end
		end
	end

	assign stat.busy = busy_q | done_q;
	assign stat.done = done_q;

endmodule
